>>> rtl/core/weighted_receiver_selector_defines.svh
// Assertion macros shared by the weighted receiver selector RTL.
`ifndef WEIGHTED_RECEIVER_SELECTOR_DEFINES_SVH
`define WEIGHTED_RECEIVER_SELECTOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define WRS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: assertion failed");

// Next-cycle implication checked outside reset.
`define WRS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: assertion failed");

`endif

>>> rtl/core/wrs_pkg.sv
//------------------------------------------------------------------------------
// wrs_pkg
// Shared constants and types for the weighted receiver selector.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int unsigned MaxReceivers = 16;
  localparam int unsigned IdxW         = $clog2(MaxReceivers);
  localparam int unsigned CntW         = $clog2(MaxReceivers + 1);
  localparam int unsigned WeightW      = 17;
  localparam int unsigned IdW          = 8;
  localparam logic [WeightW-1:0] FullWeight = 17'd65536;
  localparam logic [13:0] DrawScale   = 14'd10000;

  localparam logic [2:0] ActAddEqual    = 3'd0;
  localparam logic [2:0] ActAddWeighted = 3'd1;
  localparam logic [2:0] ActRemove      = 3'd2;
  localparam logic [2:0] ActDraw        = 3'd3;
  localparam logic [2:0] ActRead        = 3'd4;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StFull   = 3'd1;
  localparam logic [2:0] StDup    = 3'd2;
  localparam logic [2:0] StAbsent = 3'd3;
  localparam logic [2:0] StNone   = 3'd4;

  // Request to the divider: quotient = num / den, num up to 34 bits.
  typedef struct packed {
    logic        start;
    logic [33:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] quo;
  } div_rsp_t;

endpackage

>>> rtl/core/wrs_divider.sv
//------------------------------------------------------------------------------
// wrs_divider
// Restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrs_divider
  import wrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [33:0] quo_q, quo_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[16:0], quo_q[33]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[32:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> rtl/core/wrs_table_ram.sv
//------------------------------------------------------------------------------
// wrs_table_ram
// Receiver table: id and weight per slot, one write and one registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrs_table_ram
  import wrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IdxW-1:0]    waddr_i,
  input  logic [IdW-1:0]     wid_i,
  input  logic [WeightW-1:0] wweight_i,
  input  logic [IdxW-1:0]    raddr_i,
  output logic [IdW-1:0]     rid_o,
  output logic [WeightW-1:0] rweight_o
);

  logic [IdW+WeightW-1:0] mem [MaxReceivers];
  logic [IdW+WeightW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wid_i, wweight_i};
    end
    rdata_q <= mem[raddr_i];
  end

  assign rid_o     = rdata_q[IdW+WeightW-1:WeightW];
  assign rweight_o = rdata_q[WeightW-1:0];

endmodule

>>> rtl/core/weighted_receiver_selector.sv
//------------------------------------------------------------------------------
// weighted_receiver_selector
// Sorted receiver table with weight rescaling and cumulative weighted draw.
//------------------------------------------------------------------------------
// Channel  Dir  tdata fields (low bit first)                  tuser
// s_axis   in   receiver_id, new_weight, random_value, slot_index  action
// m_axis   out  status, out_id, out_weight, slot_valid, entry_total  -
//
// One request at a time. Each request makes passes over the table RAM; a rescale
// or shift reads a slot and then writes it back. Remove runs each remaining slot
// through the 34-step divider unless the removed entry held the full weight.
// Reset clears the entry count and the control state but not the table.
// The result sits in an output register, so the next request is taken while
// it waits; a finished request holds until that register is free.
`timescale 1ns / 1ps

module weighted_receiver_selector
  import wrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // receiver_id[7:0], new_weight[24:8], random_value[38:25], slot_index[42:39]
  input  logic [47:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], out_id[10:3], out_weight[27:11], slot_valid[28], entry_total[33:29]
  output logic [39:0] m_axis_tdata
);

`include "weighted_receiver_selector_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_SCALE_RD, S_SCALE_DIV,
    S_SCALE_WAIT, S_SHIFT_RD, S_SHIFT_WR, S_DRAW_RD, S_DRAW_CHK, S_DONE
  } state_e;

  state_e state_q;

  logic [2:0]         act_q;
  logic [IdW-1:0]     id_q;
  logic [WeightW-1:0] p_q;
  logic [13:0]        rnd_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    i_q;
  logic [CntW-1:0]    pos_q;
  logic               found_q;
  logic [WeightW-1:0] d_q;
  logic [WeightW-1:0] eqw_q;
  logic [20:0]        sum_q;
  logic [WeightW-1:0] w_hold_q;
  logic               out_busy_q;
  logic [2:0]         o_status_q;
  logic [IdW-1:0]     o_id_q;
  logic [WeightW-1:0] o_weight_q;
  logic               o_valid_q;
  logic [2:0]         out_status_q;
  logic [IdW-1:0]     out_id_q;
  logic [WeightW-1:0] out_weight_q;
  logic               out_valid_q;
  logic [CntW-1:0]    out_total_q;

  logic               we;
  logic [IdxW-1:0]    waddr, raddr;
  logic [IdW-1:0]     wid, rid;
  logic [WeightW-1:0] wweight, rweight;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic [20:0]        sum_n;
  logic [WeightW-1:0] scaled;
  logic [32:0]        scale_prod;
  logic               out_load;

  // Equal share floor(65536 / (n + 1)) when n entries are already present.
  function automatic logic [WeightW-1:0] eq_weight(input logic [IdxW-1:0] n);
    logic [WeightW-1:0] w;
    case (n)
      4'd0:    w = 17'd65536;
      4'd1:    w = 17'd32768;
      4'd2:    w = 17'd21845;
      4'd3:    w = 17'd16384;
      4'd4:    w = 17'd13107;
      4'd5:    w = 17'd10922;
      4'd6:    w = 17'd9362;
      4'd7:    w = 17'd8192;
      4'd8:    w = 17'd7281;
      4'd9:    w = 17'd6553;
      4'd10:   w = 17'd5957;
      4'd11:   w = 17'd5461;
      4'd12:   w = 17'd5041;
      4'd13:   w = 17'd4681;
      4'd14:   w = 17'd4369;
      default: w = 17'd4096;
    endcase
    return w;
  endfunction

  wrs_table_ram u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wid_i    (wid),
    .wweight_i(wweight),
    .raddr_i  (raddr),
    .rid_o    (rid),
    .rweight_o(rweight)
  );

  wrs_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_busy_q;
  assign m_axis_tdata  = {6'd0, out_total_q, out_valid_q, out_weight_q, out_id_q,
                          out_status_q};
  // An insert reads the slot below the one it writes.
  assign raddr         = (state_q == S_SHIFT_RD && act_q != ActRemove)
                         ? i_q[IdxW-1:0] - IdxW'(1) : i_q[IdxW-1:0];
  assign sum_n         = sum_q + {4'd0, rweight};
  assign scaled        = (drsp.quo > {17'd0, FullWeight}) ? FullWeight : drsp.quo[16:0];
  assign scale_prod    = 33'(rweight) * 33'(FullWeight - p_q);
  assign out_load      = (state_q == S_DONE) && (!out_busy_q || m_axis_tready);

  // Table writes and divider starts are combinational from state.
  always_comb begin
    we      = 1'b0;
    waddr   = i_q[IdxW-1:0];
    wid     = rid;
    wweight = rweight;
    dreq    = '0;
    unique case (state_q)
      S_SCALE_DIV: begin
        if (act_q == ActAddEqual) begin
          we      = 1'b1;
          wweight = eqw_q;
        end else if (act_q == ActAddWeighted) begin
          we      = 1'b1;
          wweight = scale_prod[32:16];
        end else if (d_q < FullWeight) begin
          dreq.start = 1'b1;
          dreq.num   = {rweight, 17'd0} >> 1;
          dreq.den   = FullWeight - d_q;
        end else begin
          we      = 1'b1;
          wweight = (rweight != '0) ? FullWeight : '0;
        end
      end
      S_SCALE_WAIT: begin
        we      = drsp.done;
        wweight = scaled;
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        if (act_q == ActRemove) begin
          waddr = i_q[IdxW-1:0] - IdxW'(1);
        end else if (i_q == pos_q) begin
          wid     = id_q;
          wweight = w_hold_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      out_busy_q <= 1'b0;
    end else begin
      if (out_load) out_busy_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_busy_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            act_q      <= s_axis_tuser;
            id_q       <= s_axis_tdata[7:0];
            p_q        <= (s_axis_tdata[24:8] > FullWeight) ? FullWeight : s_axis_tdata[24:8];
            rnd_q      <= s_axis_tdata[38:25];
            i_q        <= (s_axis_tuser == ActRead) ? {1'b0, s_axis_tdata[42:39]} : '0;
            pos_q      <= cnt_q;
            found_q    <= 1'b0;
            sum_q      <= '0;
            o_status_q <= StOk;
            o_id_q     <= '0;
            o_weight_q <= '0;
            o_valid_q  <= 1'b0;
            unique case (s_axis_tuser)
              ActAddEqual, ActAddWeighted, ActRemove: state_q <= S_SCAN_RD;
              ActDraw: state_q <= S_DRAW_RD;
              ActRead: begin
                if ({1'b0, s_axis_tdata[42:39]} < cnt_q) state_q <= S_DRAW_RD;
                else state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        // Find the id (or the first larger id) for inserts and removes.
        S_SCAN_RD: begin
          if (i_q >= cnt_q) state_q <= S_DECIDE;
          else state_q <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (rid == id_q) begin
            found_q <= 1'b1;
            pos_q   <= i_q;
            d_q     <= rweight;
            state_q <= S_DECIDE;
          end else begin
            if (rid > id_q && pos_q == cnt_q) pos_q <= i_q;
            i_q     <= i_q + CntW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_DECIDE: begin
          if (act_q == ActRemove) begin
            if (!found_q) begin
              o_status_q <= StAbsent;
              state_q    <= S_DONE;
            end else begin
              i_q     <= pos_q + CntW'(1);
              state_q <= S_SHIFT_RD;
            end
          end else if (found_q) begin
            o_status_q <= StDup;
            state_q    <= S_DONE;
          end else if (cnt_q >= CntW'(MaxReceivers)) begin
            o_status_q <= StFull;
            state_q    <= S_DONE;
          end else begin
            if (act_q == ActAddEqual) begin
              eqw_q    <= eq_weight(cnt_q[IdxW-1:0]);
              w_hold_q <= eq_weight(cnt_q[IdxW-1:0]);
            end else begin
              w_hold_q <= (cnt_q == '0) ? FullWeight : p_q;
            end
            i_q     <= '0;
            state_q <= S_SCALE_RD;
          end
        end
        // Rescale every present entry: read, compute, write back.
        S_SCALE_RD: begin
          if (i_q >= cnt_q) begin
            if (act_q == ActRemove) begin
              state_q <= S_DONE;
            end else begin
              i_q     <= cnt_q;
              state_q <= (pos_q == cnt_q) ? S_SHIFT_WR : S_SHIFT_RD;
            end
          end else begin
            state_q <= S_SCALE_DIV;
          end
        end
        S_SCALE_DIV: begin
          if (we) begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_SCALE_RD;
          end else begin
            state_q <= S_SCALE_WAIT;
          end
        end
        S_SCALE_WAIT: begin
          if (drsp.done) begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_SCALE_RD;
          end
        end
        // Shift entries: up from the end on insert, down after a remove.
        S_SHIFT_RD: begin
          if (act_q == ActRemove) begin
            if (i_q >= cnt_q) begin
              cnt_q   <= cnt_q - CntW'(1);
              i_q     <= '0;
              state_q <= S_SCALE_RD;
            end else begin
              state_q <= S_SHIFT_WR;
            end
          end else begin
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          if (act_q == ActRemove) begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_SHIFT_RD;
          end else if (i_q == pos_q) begin
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= S_DONE;
          end else begin
            i_q     <= i_q - CntW'(1);
            state_q <= ((i_q - CntW'(1)) == pos_q) ? S_SHIFT_WR : S_SHIFT_RD;
          end
        end
        // Draw walk, also used for a single-slot read.
        S_DRAW_RD: begin
          if (act_q == ActDraw && i_q >= cnt_q) begin
            o_status_q <= StNone;
            state_q    <= S_DONE;
          end else begin
            state_q <= S_DRAW_CHK;
          end
        end
        S_DRAW_CHK: begin
          if (act_q == ActRead) begin
            o_valid_q  <= 1'b1;
            o_id_q     <= rid;
            o_weight_q <= rweight;
            state_q    <= S_DONE;
          end else begin
            sum_q <= sum_n;
            if (35'(sum_n) * 35'(DrawScale) > 35'({rnd_q, 16'd0})) begin
              o_id_q     <= rid;
              o_weight_q <= rweight;
              state_q    <= S_DONE;
            end else begin
              i_q     <= i_q + CntW'(1);
              state_q <= S_DRAW_RD;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= o_status_q;
      out_id_q     <= o_id_q;
      out_weight_q <= o_weight_q;
      out_valid_q  <= o_valid_q;
      out_total_q  <= cnt_q;
    end
  end

  `WRS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxReceivers))
  `WRS_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `WRS_ASSERT_NEXT(a_done_out, clk_i, rst_ni, out_load, out_busy_q)
  `WRS_ASSERT_IMP(a_wr_inrange, clk_i, rst_ni, we, {1'b0, waddr} <= cnt_q)

endmodule
